/* hw/rtl/motor_feedback_frame_parser_assert.svh */
// Assertion macros shared by the feedback frame parser modules.
// Expects the including module to have clk and rst_n in scope.
`ifndef MOTOR_FEEDBACK_FRAME_PARSER_ASSERT_SVH
`define MOTOR_FEEDBACK_FRAME_PARSER_ASSERT_SVH

// cond holds at every clock edge out of reset
`define MFFP_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// cons holds in the same cycle as ante
`define MFFP_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// cons holds in the cycle after ante
`define MFFP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/mffp_pkg.sv */
// Shared types and constants for the motor feedback frame parser.
// No dependencies; used by every module of the block.
package mffp_pkg;

    localparam int unsigned FRAME_BYTES_INT = 18;
    localparam logic [4:0]  FRAME_BYTES     = 5'(FRAME_BYTES_INT);
    localparam logic [4:0]  CKSUM_POS       = 5'(FRAME_BYTES_INT - 2);
    localparam logic [4:0]  FIRST_BODY_POS  = 5'd2;
    localparam int unsigned QUEUE_DEPTH     = 2;

    // Word slots of a frame body (start and checksum words are not kept)
    localparam int unsigned W_ECHO_ONE    = 0;
    localparam int unsigned W_ECHO_TWO    = 1;
    localparam int unsigned W_SPEED_RIGHT = 2;
    localparam int unsigned W_SPEED_LEFT  = 3;
    localparam int unsigned W_BATTERY     = 4;
    localparam int unsigned W_TEMP        = 5;
    localparam int unsigned W_LED         = 6;
    localparam int unsigned BODY_WORDS    = 7;

    // Configuration register indexes
    localparam logic [2:0] REG_START_WORD = 3'd0;
    localparam logic [2:0] REG_BAT_MIN    = 3'd1;
    localparam logic [2:0] REG_BAT_MAX    = 3'd2;
    localparam logic [2:0] REG_TEMP_MIN   = 3'd3;
    localparam logic [2:0] REG_TEMP_MAX   = 3'd4;

    typedef enum logic [1:0] {
        KIND_BYTE  = 2'd0,
        KIND_CLEAR = 2'd1,
        KIND_GOOD  = 2'd2,
        KIND_BAD   = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t                         kind;
        logic [BODY_WORDS-1:0][15:0]   words;
    } entry_t;

    typedef struct packed {
        logic        [15:0] start_word;
        logic signed [15:0] bat_min;
        logic signed [15:0] bat_max;
        logic signed [15:0] temp_min;
        logic signed [15:0] temp_max;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        start_word: 16'hABCD,
        bat_min:    16'sd1500,
        bat_max:    16'sd6000,
        temp_min:   -16'sd400,
        temp_max:   16'sd600
    };

endpackage

/* hw/rtl/mffp_front.sv */
// Front end: byte framing, resync on start word, running checksum, frame capture.
// Depends on mffp_pkg and motor_feedback_frame_parser_assert.svh.
`include "motor_feedback_frame_parser_assert.svh"

module mffp_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_fire,
    input  logic              req_type,
    input  logic [7:0]        data_byte,
    input  logic [15:0]       start_word,
    output mffp_pkg::entry_t  entry
);

    logic [7:0]  prev_byte_reg;
    logic [4:0]  byte_count_reg;
    logic [15:0] word0_reg;
    logic [15:0] csum_reg;
    logic [7:0]  ck_lo_reg;
    logic [mffp_pkg::BODY_WORDS-1:0][15:0] words_reg;

    logic [15:0] pair;
    logic        resync;
    logic        collecting;
    logic        done;
    logic        good;
    logic [2:0]  wsel;
    logic        byte_in;

    assign byte_in = in_fire && !req_type;

    always_comb
    begin
        pair       = {data_byte, prev_byte_reg};
        resync     = (pair == start_word);
        collecting = (byte_count_reg >= mffp_pkg::FIRST_BODY_POS) &&
                     (byte_count_reg < mffp_pkg::FRAME_BYTES);
        done       = !resync && (byte_count_reg == mffp_pkg::FRAME_BYTES - 5'd1);
        good       = (word0_reg == start_word) && (csum_reg == {data_byte, ck_lo_reg});
        // positions 2..15 map onto body words 0..6
        wsel       = byte_count_reg[3:1] - 3'd1;

        entry.words = words_reg;
        if (req_type)
            entry.kind = mffp_pkg::KIND_CLEAR;
        else if (done)
            entry.kind = good ? mffp_pkg::KIND_GOOD : mffp_pkg::KIND_BAD;
        else
            entry.kind = mffp_pkg::KIND_BYTE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_byte_reg  <= 8'd0;
            byte_count_reg <= 5'd0;
        end
        else if (byte_in)
        begin
            prev_byte_reg <= data_byte;
            if (resync)
                byte_count_reg <= mffp_pkg::FIRST_BODY_POS;
            else if (done)
                byte_count_reg <= 5'd0;
            else if (collecting)
                byte_count_reg <= byte_count_reg + 5'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_in)
        begin
            if (resync)
            begin
                word0_reg <= pair;
                csum_reg  <= pair;
            end
            else if (collecting)
            begin
                if (byte_count_reg < mffp_pkg::CKSUM_POS)
                begin
                    if (byte_count_reg[0])
                    begin
                        words_reg[wsel][15:8] <= data_byte;
                        csum_reg[15:8]        <= csum_reg[15:8] ^ data_byte;
                    end
                    else
                    begin
                        words_reg[wsel][7:0] <= data_byte;
                        csum_reg[7:0]        <= csum_reg[7:0] ^ data_byte;
                    end
                end
                else if (byte_count_reg == mffp_pkg::CKSUM_POS)
                begin
                    ck_lo_reg <= data_byte;
                end
            end
        end
    end

    `MFFP_ASSERT_ALWAYS(a_count_range,
        byte_count_reg != 5'd1 && byte_count_reg < mffp_pkg::FRAME_BYTES,
        "frame byte count out of range")
    `MFFP_ASSERT_NEXT(a_done_to_idle, byte_in && done, byte_count_reg == 5'd0,
        "parser not idle after frame completion")

endmodule

/* hw/rtl/mffp_queue.sv */
// Two-entry queue between the framing front end and the telemetry back end.
// Depends on mffp_pkg and motor_feedback_frame_parser_assert.svh.
`include "motor_feedback_frame_parser_assert.svh"

module mffp_queue
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  mffp_pkg::entry_t  push_data,
    input  logic              pop,
    output mffp_pkg::entry_t  pop_data,
    output logic              full,
    output logic              not_empty
);

    mffp_pkg::entry_t mem_reg [mffp_pkg::QUEUE_DEPTH];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full      = (count_reg == 2'(mffp_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != 2'd0);
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    `MFFP_ASSERT_IMPLIES(a_no_overflow, push, !full || pop, "push into full queue")
    `MFFP_ASSERT_IMPLIES(a_no_underflow, pop, not_empty, "pop from empty queue")

endmodule

/* hw/rtl/mffp_back.sv */
// Back end: held telemetry, sticky fault latch, battery low-pass, result register.
// Depends on mffp_pkg and motor_feedback_frame_parser_assert.svh.
`include "motor_feedback_frame_parser_assert.svh"

module mffp_back
#(
    parameter int unsigned FILTER_SHIFT = 2
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  mffp_pkg::cfg_t                         cfg,
    input  logic                                   entry_valid,
    input  mffp_pkg::entry_t                       entry,
    output logic                                   take,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic                                   frame_ok,
    output logic                                   frame_bad,
    output logic [mffp_pkg::BODY_WORDS-1:0][15:0]  held,
    output logic                                   fault_flag,
    output logic signed [23:0]                     battery_filtered
);

    logic                                  out_valid_reg;
    logic                                  ok_reg;
    logic                                  bad_reg;
    logic                                  fault_reg;
    logic                                  fault_next;
    logic signed [23:0]                    lp_reg;
    logic signed [23:0]                    lp_next;
    logic [mffp_pkg::BODY_WORDS-1:0][15:0] held_reg;

    logic signed [15:0] bat;
    logic signed [15:0] tmp;
    logic signed [23:0] target;
    logic signed [24:0] diff;
    logic signed [24:0] step;
    logic signed [24:0] sum;
    logic               out_of_range;
    logic               is_good;

    assign take = entry_valid && (!out_valid_reg || out_ready);

    always_comb
    begin
        is_good      = (entry.kind == mffp_pkg::KIND_GOOD);
        bat          = entry.words[mffp_pkg::W_BATTERY];
        tmp          = entry.words[mffp_pkg::W_TEMP];
        out_of_range = (bat < cfg.bat_min) || (bat > cfg.bat_max) ||
                       (tmp < cfg.temp_min) || (tmp >= cfg.temp_max);
        target       = {bat, 8'h00};
        diff         = {target[23], target} - {lp_reg[23], lp_reg};
        step         = diff >>> FILTER_SHIFT;   // floor for negative steps
        sum          = {lp_reg[23], lp_reg} + step;

        if (lp_reg[23] || lp_reg == 24'sd0)
            lp_next = target;
        else
            lp_next = sum[23:0];

        fault_next = fault_reg;
        case (entry.kind)
            mffp_pkg::KIND_CLEAR: fault_next = 1'b0;
            mffp_pkg::KIND_GOOD:  fault_next = fault_reg || out_of_range;
            default:              fault_next = fault_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            ok_reg        <= 1'b0;
            bad_reg       <= 1'b0;
            fault_reg     <= 1'b0;
            lp_reg        <= 24'sd0;
            held_reg      <= '0;
        end
        else
        begin
            if (take)
            begin
                out_valid_reg <= 1'b1;
                ok_reg        <= is_good;
                bad_reg       <= (entry.kind == mffp_pkg::KIND_BAD);
                fault_reg     <= fault_next;
                if (is_good)
                begin
                    held_reg <= entry.words;
                    lp_reg   <= lp_next;
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid        = out_valid_reg;
    assign frame_ok         = ok_reg;
    assign frame_bad        = bad_reg;
    assign held             = held_reg;
    assign fault_flag       = fault_reg;
    assign battery_filtered = lp_reg;

    `MFFP_ASSERT_ALWAYS(a_ok_bad_excl, !(ok_reg && bad_reg), "frame both good and bad")
    `MFFP_ASSERT_NEXT(a_lp_load,
        take && is_good && (lp_reg[23] || lp_reg == 24'sd0),
        lp_reg == {$past(bat), 8'h00},
        "low-pass did not load from empty state")
    `MFFP_ASSERT_NEXT(a_clear_fault, take && entry.kind == mffp_pkg::KIND_CLEAR,
        !fault_reg, "clear request left fault set")

endmodule

/* hw/rtl/motor_feedback_frame_parser.sv */
// Motor board serial feedback parser. Each request is one received UART byte
// (tuser 0) or a fault clear (tuser 1) and yields exactly one result holding
// the frame status and the telemetry of the last good frame. It takes one request
// per clock while the queue is not full: the framing front end runs in the accept
// cycle, a two-entry queue decouples it from the back end, which updates telemetry,
// fault latch and battery low-pass once per entry into an output register. Results
// pass the queue register, then the output register, and one leaves per cycle while
// the output is taken. The user writes configuration through a plain write port
// only while no request is in flight; the block itself does not enforce this.
// Depends on mffp_pkg, mffp_front, mffp_queue and mffp_back.

module motor_feedback_frame_parser
#(
    parameter int unsigned FILTER_SHIFT = 2
)
(
    input  logic         clk,
    input  logic         rst_n,

    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,    // [7:0] data_byte
    input  logic [0:0]   s_tuser,    // [0] req_type

    output logic         m_tvalid,
    input  logic         m_tready,
    // [15:0] echo_one, [31:16] echo_two, [47:32] speed_right, [63:48] speed_left,
    // [79:64] battery_raw, [95:80] temp_raw, [111:96] led_word, [112] fault_flag,
    // [136:113] battery_filtered, [143:137] zero
    output logic [143:0] m_tdata,
    output logic [1:0]   m_tuser,    // [0] frame_ok, [1] frame_bad

    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [15:0]  cfg_data
);

    mffp_pkg::cfg_t   cfg_reg;
    mffp_pkg::entry_t front_entry;
    mffp_pkg::entry_t queue_entry;

    logic        in_fire;
    logic        q_full;
    logic        q_not_empty;
    logic        take;
    logic        frame_ok;
    logic        frame_bad;
    logic        fault_flag;
    logic signed [23:0] battery_filtered;
    logic [mffp_pkg::BODY_WORDS-1:0][15:0] held;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= mffp_pkg::CFG_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mffp_pkg::REG_START_WORD: cfg_reg.start_word <= cfg_data;
                mffp_pkg::REG_BAT_MIN:    cfg_reg.bat_min    <= cfg_data;
                mffp_pkg::REG_BAT_MAX:    cfg_reg.bat_max    <= cfg_data;
                mffp_pkg::REG_TEMP_MIN:   cfg_reg.temp_min   <= cfg_data;
                mffp_pkg::REG_TEMP_MAX:   cfg_reg.temp_max   <= cfg_data;
                default:                  cfg_reg            <= cfg_reg;
            endcase
        end
    end

    assign s_tready = !q_full;
    assign in_fire  = s_tvalid && s_tready;

    mffp_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_fire    (in_fire),
        .req_type   (s_tuser[0]),
        .data_byte  (s_tdata),
        .start_word (cfg_reg.start_word),
        .entry      (front_entry)
    );

    mffp_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_fire),
        .push_data (front_entry),
        .pop       (take),
        .pop_data  (queue_entry),
        .full      (q_full),
        .not_empty (q_not_empty)
    );

    mffp_back
    #(
        .FILTER_SHIFT (FILTER_SHIFT)
    )
    u_back
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg              (cfg_reg),
        .entry_valid      (q_not_empty),
        .entry            (queue_entry),
        .take             (take),
        .out_valid        (m_tvalid),
        .out_ready        (m_tready),
        .frame_ok         (frame_ok),
        .frame_bad        (frame_bad),
        .held             (held),
        .fault_flag       (fault_flag),
        .battery_filtered (battery_filtered)
    );

    assign m_tuser = {frame_bad, frame_ok};
    assign m_tdata = {7'd0, battery_filtered, fault_flag, held};

endmodule
